// File: rtl/core/gbn_pkg.sv
package gbn_pkg;

  localparam int MAX_SEQ_DEF = 7;
  localparam int MAX_RESULTS = 9;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] DATA_TO_RST = 16'd2000;
  localparam logic [15:0] ACK_TO_RST = 16'd500;
  localparam logic [9:0] MIN_FRAME_LEN = 10'd5;
  localparam logic [9:0] HDR_LEN = 10'd7;

  localparam logic [2:0] OP_PKT = 3'd0;
  localparam logic [2:0] OP_PHY = 3'd1;
  localparam logic [2:0] OP_FRAME = 3'd2;
  localparam logic [2:0] OP_DTO = 3'd3;
  localparam logic [2:0] OP_ATO = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;

  localparam logic REG_DATA_TO = 1'b0;
  localparam logic REG_ACK_TO = 1'b1;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_DATA = 3'd1,
    ACT_ACK = 3'd2,
    ACT_DELIVER = 3'd3,
    ACT_STOP = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_ACK,
    S_STOP,
    S_RESEND
  } state_t;

  typedef struct packed {
    logic    load;
    logic    emit;
    action_t act;
    logic    last;
    logic    inc_buf;
    logic    dec_buf;
    logic    set_ready;
    logic    clr_ready;
    logic    adv_next;
    logic    next_from_oldest;
    logic    adv_oldest;
    logic    adv_exp;
    logic    walk_max;
    logic    walk_cnt;
    logic    walk_dec;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       kind_data;
    logic       frame_ok;
    logic       seq_match;
    logic       cnt_lt_max;
    logic       cnt_zero;
    logic       inwin;
    logic       inwin_next;
    logic       walk_one;
    logic       go;
  } status_t;

endpackage

// File: rtl/core/go_back_n_arq_engine.sv
// channel  | handshake            | contents
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_ready  | opcode, frame_kind, frame_seq, peer_ack,
//          |                      | frame_length, crc_good
// output   | out_valid / out_ready| action, seq_number, ack_number, timer_value,
//          |                      | payload_length, network_enable, last
// config   | cfg_wr_en            | cfg_index (0 data timeout, 1 ack timeout),
//          |                      | cfg_data
//
// One request at a time: the request is accepted, then dispatch issues the first
// result or none and the walk states issue the rest (9 results at most).
// Ack releases and timeout resends walk the window one sequence number a cycle.
// A stalled output holds the walk; the next request is taken while the final
// result still waits in the output register.
// rst is synchronous: sequence state, buffered count, ready flag and out_valid
// clear, timeouts return to 2000 and 500.
module go_back_n_arq_engine import gbn_pkg::*; #(
  parameter int MAX_SEQUENCE = MAX_SEQ_DEF,
  localparam int SW = $clog2(MAX_SEQUENCE + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    opcode,
  input  logic [1:0]    frame_kind,
  input  logic [SW-1:0] frame_seq,
  input  logic [SW-1:0] peer_ack,
  input  logic [9:0]    frame_length,
  input  logic          crc_good,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    action,
  output logic [SW-1:0] seq_number,
  output logic [SW-1:0] ack_number,
  output logic [15:0]   timer_value,
  output logic [9:0]    payload_length,
  output logic          network_enable,
  output logic          last
);

  cmd_t    cmd;
  status_t sts;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbn_dp #(
    .MAX_SEQUENCE (MAX_SEQUENCE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .frame_kind     (frame_kind),
    .frame_seq      (frame_seq),
    .peer_ack       (peer_ack),
    .frame_length   (frame_length),
    .crc_good       (crc_good),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .seq_number     (seq_number),
    .ack_number     (ack_number),
    .timer_value    (timer_value),
    .payload_length (payload_length),
    .network_enable (network_enable),
    .last           (last),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// File: rtl/core/gbn_dp.sv
module gbn_dp import gbn_pkg::*; #(
  parameter int MAX_SEQUENCE = MAX_SEQ_DEF,
  localparam int SW = $clog2(MAX_SEQUENCE + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic [2:0]    opcode,
  input  logic [1:0]    frame_kind,
  input  logic [SW-1:0] frame_seq,
  input  logic [SW-1:0] peer_ack,
  input  logic [9:0]    frame_length,
  input  logic          crc_good,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    action,
  output logic [SW-1:0] seq_number,
  output logic [SW-1:0] ack_number,
  output logic [15:0]   timer_value,
  output logic [9:0]    payload_length,
  output logic          network_enable,
  output logic          last,
  input  cmd_t          cmd,
  output status_t       sts
);

  localparam logic [SW-1:0] SEQ_MAX = SW'(MAX_SEQUENCE);

  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] k);
    return (k == SEQ_MAX) ? '0 : SW'(k + SW'(1));
  endfunction

  function automatic logic in_window(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                     input logic [SW-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  logic [15:0]    data_to, ack_to;
  logic [SW-1:0]  next_seq, oldest_seq, exp_seq, buf_cnt, walk;
  logic           phy_ready;
  logic [RES_W-1:0] res_cnt;
  logic [2:0]     lat_op;
  logic [1:0]     lat_kind;
  logic [SW-1:0]  lat_seq, lat_ack;
  logic [9:0]     lat_len;
  logic           lat_crc, lat_en;
  logic           drop, fire, en_calc, cnt_lt_max, in_ok, in_win0;
  logic           out_valid_next;

  assign cnt_lt_max = buf_cnt < SEQ_MAX;
  assign drop = res_cnt >= RES_W'(MAX_RESULTS);
  assign fire = cmd.emit && !drop;
  assign in_ok = (frame_length >= MIN_FRAME_LEN) && crc_good;
  assign in_win0 = in_window(oldest_seq, peer_ack, next_seq);

  always_comb begin
    unique case (opcode)
      OP_PKT: en_calc = 1'b0;
      OP_PHY: en_calc = cnt_lt_max;
      OP_FRAME: begin
        if (!in_ok) begin
          en_calc = phy_ready && cnt_lt_max;
        end else if (frame_kind == KIND_DATA) begin
          en_calc = 1'b0;
        end else begin
          en_calc = phy_ready && (cnt_lt_max || in_win0);
        end
      end
      OP_DTO: en_calc = (buf_cnt == '0) ? phy_ready : 1'b0;
      OP_ATO: en_calc = 1'b0;
      default: en_calc = phy_ready && cnt_lt_max;
    endcase
  end

  always_comb begin
    sts.opcode = lat_op;
    sts.kind_data = lat_kind == KIND_DATA;
    sts.frame_ok = (lat_len >= MIN_FRAME_LEN) && lat_crc;
    sts.seq_match = lat_seq == exp_seq;
    sts.cnt_lt_max = cnt_lt_max;
    sts.cnt_zero = buf_cnt == '0;
    sts.inwin = in_window(oldest_seq, lat_ack, next_seq);
    sts.inwin_next = in_window(seq_inc(oldest_seq), lat_ack, next_seq);
    sts.walk_one = walk == SW'(1);
    sts.go = !out_valid || out_ready || drop;
  end

  assign out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      data_to <= DATA_TO_RST;
      ack_to <= ACK_TO_RST;
      next_seq <= '0;
      oldest_seq <= '0;
      exp_seq <= '0;
      buf_cnt <= '0;
      phy_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == REG_DATA_TO) begin
        data_to <= cfg_data;
      end
      if (cfg_wr_en && cfg_index == REG_ACK_TO) begin
        ack_to <= cfg_data;
      end
      out_valid <= out_valid_next;
      if (cmd.inc_buf) begin
        buf_cnt <= SW'(buf_cnt + SW'(1));
      end else if (cmd.dec_buf && buf_cnt != '0) begin
        buf_cnt <= SW'(buf_cnt - SW'(1));
      end
      if (cmd.set_ready) begin
        phy_ready <= 1'b1;
      end else if (cmd.clr_ready) begin
        phy_ready <= 1'b0;
      end
      if (cmd.next_from_oldest) begin
        next_seq <= oldest_seq;
      end else if (cmd.adv_next) begin
        next_seq <= seq_inc(next_seq);
      end
      if (cmd.adv_oldest) begin
        oldest_seq <= seq_inc(oldest_seq);
      end
      if (cmd.adv_exp) begin
        exp_seq <= seq_inc(exp_seq);
      end
    end
  end

  // event latch, walk counter, result count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_op <= opcode;
      lat_kind <= frame_kind;
      lat_seq <= frame_seq;
      lat_ack <= peer_ack;
      lat_len <= frame_length;
      lat_crc <= crc_good;
      lat_en <= en_calc;
      res_cnt <= '0;
    end else if (fire) begin
      res_cnt <= RES_W'(res_cnt + RES_W'(1));
    end
    if (cmd.walk_max) begin
      walk <= SEQ_MAX;
    end else if (cmd.walk_cnt) begin
      walk <= buf_cnt;
    end else if (cmd.walk_dec) begin
      walk <= SW'(walk - SW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      action <= cmd.act;
      seq_number <= (cmd.act == ACT_DATA) ? next_seq :
                    (cmd.act == ACT_STOP) ? oldest_seq : '0;
      ack_number <= (exp_seq == '0) ? SEQ_MAX : SW'(exp_seq - SW'(1));
      timer_value <= (cmd.act == ACT_DATA) ? data_to :
                     (cmd.act == ACT_ACK) ? ack_to : 16'd0;
      payload_length <= (cmd.act == ACT_DELIVER && lat_len >= HDR_LEN) ?
                        10'(lat_len - HDR_LEN) : 10'd0;
      network_enable <= lat_en;
      last <= cmd.last || (res_cnt == RES_W'(MAX_RESULTS - 1));
    end
  end

`ifndef SYNTHESIS
  a_buf_bound: assert property (@(posedge clk) disable iff (rst) buf_cnt <= SEQ_MAX)
    else $error("buffered count above window");
  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    (next_seq <= SEQ_MAX) && (oldest_seq <= SEQ_MAX) && (exp_seq <= SEQ_MAX))
    else $error("sequence number out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> sts.go)
    else $error("result issued over a pending one");
  a_res_clear: assert property (@(posedge clk) disable iff (rst) cmd.load |=> res_cnt == '0)
    else $error("result count not cleared on new request");
`endif

endmodule

// File: rtl/core/gbn_ctrl.sv
module gbn_ctrl import gbn_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.act = ACT_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.go) begin
          unique case (sts.opcode)
            OP_PKT: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (sts.cnt_lt_max) begin
                cmd.act = ACT_DATA;
                cmd.inc_buf = 1'b1;
                cmd.clr_ready = 1'b1;
                cmd.adv_next = 1'b1;
              end
              state_next = S_IDLE;
            end
            OP_PHY: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              cmd.set_ready = 1'b1;
              state_next = S_IDLE;
            end
            OP_FRAME: begin
              cmd.walk_max = 1'b1;
              if (!sts.frame_ok) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                state_next = S_IDLE;
              end else if (sts.kind_data) begin
                if (sts.seq_match) begin
                  cmd.emit = 1'b1;
                  cmd.act = ACT_DELIVER;
                  cmd.adv_exp = 1'b1;
                end
                state_next = S_ACK;
              end else if (sts.inwin) begin
                state_next = S_STOP;
              end else begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                state_next = S_IDLE;
              end
            end
            OP_DTO: begin
              cmd.next_from_oldest = 1'b1;
              cmd.walk_cnt = 1'b1;
              if (sts.cnt_zero) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
                state_next = S_IDLE;
              end else begin
                state_next = S_RESEND;
              end
            end
            OP_ATO: begin
              cmd.emit = 1'b1;
              cmd.act = ACT_ACK;
              cmd.last = 1'b1;
              cmd.clr_ready = 1'b1;
              state_next = S_IDLE;
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ACK: begin
        if (sts.go) begin
          cmd.emit = 1'b1;
          cmd.act = ACT_ACK;
          cmd.clr_ready = 1'b1;
          cmd.last = !sts.inwin;
          state_next = sts.inwin ? S_STOP : S_IDLE;
        end
      end
      S_STOP: begin
        if (sts.go) begin
          cmd.emit = 1'b1;
          cmd.act = ACT_STOP;
          cmd.dec_buf = 1'b1;
          cmd.adv_oldest = 1'b1;
          cmd.walk_dec = 1'b1;
          cmd.last = !sts.inwin_next || sts.walk_one;
          state_next = (!sts.inwin_next || sts.walk_one) ? S_IDLE : S_STOP;
        end
      end
      S_RESEND: begin
        if (sts.go) begin
          cmd.emit = 1'b1;
          cmd.act = ACT_DATA;
          cmd.clr_ready = 1'b1;
          cmd.adv_next = 1'b1;
          cmd.walk_dec = 1'b1;
          cmd.last = sts.walk_one;
          state_next = sts.walk_one ? S_IDLE : S_RESEND;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_load: assert property (@(posedge clk) disable iff (rst) cmd.load |=> !in_ready)
    else $error("second request taken before dispatch");
  a_emit_go: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> sts.go)
    else $error("result issued while output stalled");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> in_ready)
    else $error("final result did not return to idle");
`endif

endmodule
